// ===== rtl/core/mexp_pkg.sv =====
// package for the modular exponentiation block
// sequencer state type and shared width constants; no dependencies
package mexp_pkg;

	localparam int MOD_WIDTH_DEF = 31;
	localparam int EXP_WIDTH_DEF = 32;
	localparam int BASE_WIDTH    = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_WAIT_RED,
		ST_BIT,
		ST_WAIT_MUL,
		ST_WAIT_SQR,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/core/mexp_mulmod.sv =====
// shared modular multiplier: interleaved shift-add with reduction, one multiplier bit per cycle
// depends on mexp_pkg
module mexp_mulmod #(
	parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [MOD_WIDTH-1:0]              op_a,
	input  logic [mexp_pkg::BASE_WIDTH-1:0]   op_b,
	input  logic [MOD_WIDTH-1:0]              modulus,
	output logic                              done,
	output logic [MOD_WIDTH-1:0]              product
);
	import mexp_pkg::*;

	localparam int CNT_W = $clog2(BASE_WIDTH);

	logic [MOD_WIDTH-1:0]  a_q;
	logic [BASE_WIDTH-1:0] b_q;
	logic [MOD_WIDTH-1:0]  m_q;
	logic [MOD_WIDTH-1:0]  r_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  run_q;
	logic                  done_q;

	logic [MOD_WIDTH:0]    m_ext;
	logic [MOD_WIDTH:0]    dbl;
	logic [MOD_WIDTH:0]    red1;
	logic [MOD_WIDTH:0]    sum;
	logic [MOD_WIDTH:0]    red2;
	logic [MOD_WIDTH-1:0]  r_nxt;

	always_comb begin
		m_ext = {1'b0, m_q};
		dbl   = {r_q, 1'b0};
		red1  = (dbl >= m_ext) ? dbl - m_ext : dbl;
		sum   = red1 + (b_q[BASE_WIDTH-1] ? {1'b0, a_q} : {(MOD_WIDTH+1){1'b0}});
		red2  = (sum >= m_ext) ? sum - m_ext : sum;
		r_nxt = red2[MOD_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(BASE_WIDTH - 1);
		end else if (run_q) begin
			done_q <= (cnt_q == '0);
			if (cnt_q == '0) begin
				run_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= op_a;
			b_q <= op_b;
			m_q <= modulus;
			r_q <= '0;
		end else if (run_q) begin
			r_q <= r_nxt;
			b_q <= b_q << 1;
		end
	end

	assign done    = done_q;
	assign product = r_q;

endmodule

// ===== rtl/core/modular_exponentiation.sv =====
// a transaction runs from the accepting edge through setup and a reduction of the base, then,
// for each exponent bit up to the highest set one, a multiply if the bit is set and a square;
// a zero exponent or zero modulus goes from setup straight to done
// throughput: one transaction at a time, busy stays high through the done strobe
// each modular product holds the shared shift-add multiplier until its done strobe
// the result is shown for one cycle with done, no stall; async active-low arst_n resets to idle
module modular_exponentiation #(
	parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF,
	parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [mexp_pkg::BASE_WIDTH-1:0] base_value,
	input  logic [EXP_WIDTH-1:0]            exponent,
	input  logic [MOD_WIDTH-1:0]            modulus,
	output logic                            done,
	output logic [MOD_WIDTH-1:0]            power_result
);
	import mexp_pkg::*;

	state_t                state_q;
	state_t                state_nxt;

	logic [BASE_WIDTH-1:0] base_q;
	logic [EXP_WIDTH-1:0]  exp_q;
	logic [MOD_WIDTH-1:0]  m_q;
	logic [MOD_WIDTH-1:0]  acc_q;
	logic [MOD_WIDTH-1:0]  run_q;
	logic [MOD_WIDTH-1:0]  res_q;

	logic                  mul_start;
	logic [MOD_WIDTH-1:0]  mul_a;
	logic [BASE_WIDTH-1:0] mul_b;
	logic                  mul_done;
	logic [MOD_WIDTH-1:0]  mul_product;
	logic [MOD_WIDTH-1:0]  one_red;

	assign one_red = (m_q == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);

	mexp_mulmod #(
		.MOD_WIDTH(MOD_WIDTH)
	) u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.modulus (m_q),
		.done    (mul_done),
		.product (mul_product)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_nxt = ST_SETUP;
			end
			ST_SETUP: begin
				if (exp_q == '0 || m_q == '0) state_nxt = ST_DONE;
				else state_nxt = ST_WAIT_RED;
			end
			ST_WAIT_RED: begin
				if (mul_done) state_nxt = ST_BIT;
			end
			ST_BIT: begin
				if (exp_q == '0) state_nxt = ST_DONE;
				else if (exp_q[0]) state_nxt = ST_WAIT_MUL;
				else state_nxt = ST_WAIT_SQR;
			end
			ST_WAIT_MUL: begin
				if (mul_done) state_nxt = ST_WAIT_SQR;
			end
			ST_WAIT_SQR: begin
				if (mul_done) state_nxt = ST_BIT;
			end
			ST_DONE: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		mul_start = 1'b0;
		mul_a     = run_q;
		mul_b     = BASE_WIDTH'(run_q);
		busy      = (state_q != ST_IDLE);
		done      = (state_q == ST_DONE);
		case (state_q)
			ST_SETUP: begin
				mul_a     = one_red;
				mul_b     = base_q;
				mul_start = (exp_q != '0) && (m_q != '0);
			end
			ST_BIT: begin
				mul_start = (exp_q != '0);
				if (exp_q[0]) begin
					mul_a = acc_q;
				end
			end
			ST_WAIT_MUL: begin
				mul_start = mul_done;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					base_q <= base_value;
					exp_q  <= exponent;
					m_q    <= modulus;
					acc_q  <= MOD_WIDTH'(1);
				end
			end
			ST_SETUP: begin
				if (exp_q == '0) res_q <= MOD_WIDTH'(1);
				else if (m_q == '0) res_q <= '0;
			end
			ST_WAIT_RED: begin
				if (mul_done) run_q <= mul_product;
			end
			ST_BIT: begin
				if (exp_q == '0) res_q <= acc_q;
			end
			ST_WAIT_MUL: begin
				if (mul_done) acc_q <= mul_product;
			end
			ST_WAIT_SQR: begin
				if (mul_done) begin
					run_q <= mul_product;
					exp_q <= exp_q >> 1;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign power_result = res_q;

endmodule

// ===== rtl/core/mexp_checker.sv =====
// port-level checks for the modular exponentiation block, bound to the top level
// depends on mexp_pkg and modular_exponentiation
module mexp_checker #(
	parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF,
	parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic [EXP_WIDTH-1:0] exponent,
	input logic                 done,
	input logic [MOD_WIDTH-1:0] power_result
);
	import mexp_pkg::*;

	a_done_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done outside a transaction");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted transaction did not raise busy");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done) else $error("busy or done held after result");

	a_zero_exp: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && exponent == '0 |=> ##1 done && power_result == MOD_WIDTH'(1))
		else $error("zero exponent did not give one");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && !busy, 2) |-> power_result == MOD_WIDTH'(1)
			|| power_result == '0)
		else $error("short transaction with unexpected result");

endmodule

bind modular_exponentiation mexp_checker #(
	.MOD_WIDTH(MOD_WIDTH),
	.EXP_WIDTH(EXP_WIDTH)
) u_mexp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.exponent     (exponent),
	.done         (done),
	.power_result (power_result)
);
